/* hdl/mora_pkg.sv */
`default_nettype none
package mora_pkg;

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  localparam int COL_W   = $clog2(MAX_COLS);       // column index
  localparam int WID_W   = 11;                     // row_width register
  localparam int DEPTH_W = $clog2(MAX_COLS + 1);   // stack depth / fill count
  localparam int H_W     = $clog2(MAX_ROWS + 1);   // column height
  localparam int SPAN_W  = $clog2(MAX_COLS + 1);   // rectangle width
  localparam int PROD_W  = H_W + SPAN_W;
  localparam int AREA_W  = 21;
  localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

  localparam int QDEPTH = 4;

  // stack entry in RAM: start column and bar height
  localparam int STK_W = COL_W + H_W;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [H_W-1:0]   h;
    logic             end_row;
    logic             last;
  } qent_t;

endpackage
`default_nettype wire

/* hdl/mora_ram.sv */
`default_nettype none
module mora_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hdl/mora_fifo.sv */
`default_nettype none
module mora_fifo
  import mora_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire qent_t wdata_i,
  input  wire logic  pop_i,
  output qent_t      rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int PTR_W = $clog2(QDEPTH);

  qent_t              buf_q [QDEPTH];
  logic [PTR_W-1:0]   wptr_q, rptr_q;
  logic [PTR_W:0]     cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = buf_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/mora_front.sv */
`default_nettype none
module mora_front
  import mora_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [WID_W-1:0] row_width_i,
  input  wire logic             push_i,
  input  wire logic             cell_i,
  input  wire logic             last_i,
  output logic                  full_o,
  output logic                  q_push_o,
  output qent_t                 q_data_o,
  input  wire logic             q_full_i
);

  typedef enum logic {F_IDLE, F_UPD} fstate_e;

  fstate_e            state_q, state_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [DEPTH_W-1:0] fill_q, fill_d;   // columns below fill hold a written height
  logic               cell_q, cell_d, last_q, last_d, end_q, end_d;

  logic [WID_W-1:0]   width;
  logic [WID_W-1:0]   col_nxt;
  logic               accept;
  logic [H_W-1:0]     rd_h, old_h, new_h;
  logic               ram_we;

  assign accept  = push_i && (state_q == F_IDLE);
  assign full_o  = (state_q != F_IDLE);
  assign col_nxt = WID_W'(col_q) + 1'b1;

  always_comb begin
    width = row_width_i;
    if (row_width_i == '0) width = WID_W'(1);
    if (row_width_i > WID_W'(MAX_COLS)) width = WID_W'(MAX_COLS);
  end

  assign old_h = (DEPTH_W'(col_q) < fill_q) ? rd_h : '0;
  always_comb begin
    if (!cell_q) begin
      new_h = '0;
    end else if (old_h < H_W'(MAX_ROWS)) begin
      new_h = old_h + 1'b1;
    end else begin
      new_h = H_W'(MAX_ROWS);
    end
  end

  assign ram_we   = (state_q == F_UPD) && !q_full_i;
  assign q_push_o = ram_we;
  assign q_data_o = '{col: col_q, h: new_h, end_row: end_q, last: last_q};

  mora_ram #(.WIDTH(H_W), .DEPTH(MAX_COLS)) u_hram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_q),
    .wdata_i (new_h),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (rd_h)
  );

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    fill_d  = fill_q;
    cell_d  = cell_q;
    last_d  = last_q;
    end_d   = end_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          cell_d  = cell_i;
          last_d  = last_i;
          end_d   = last_i || (col_nxt >= width);
          state_d = F_UPD;
        end
      end
      F_UPD: begin
        if (!q_full_i) begin
          col_d = end_q ? '0 : col_q + 1'b1;
          if (last_q) begin
            fill_d = '0;
          end else if (DEPTH_W'(col_nxt) > fill_q) begin
            fill_d = DEPTH_W'(col_nxt);
          end
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      col_q   <= '0;
      fill_q  <= '0;
      cell_q  <= 1'b0;
      last_q  <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      fill_q  <= fill_d;
      cell_q  <= cell_d;
      last_q  <= last_d;
      end_q   <= end_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/mora_back.sv */
`default_nettype none
module mora_back
  import mora_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire qent_t             q_data_i,
  output logic                   q_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic [AREA_W-1:0]      largest_area_o
);

  typedef enum logic [1:0] {B_IDLE, B_CMP, B_LOAD, B_FLUSH} bstate_e;

  bstate_e             state_q, state_d;
  logic [DEPTH_W-1:0]  depth_q, depth_d;
  logic [COL_W-1:0]    top_start_q, top_start_d, start_q, start_d, col_q, col_d;
  logic [H_W-1:0]      top_h_q, top_h_d, h_q, h_d;
  logic                end_q, end_d, last_q, last_d, flush_q, flush_d;
  logic [AREA_W-1:0]   best_q, best_d, area_q, area_d;
  logic                outv_q, outv_d;

  logic                we, re;
  logic [COL_W-1:0]    waddr, raddr;
  logic [STK_W-1:0]    rdata;
  logic                score_en;
  logic [SPAN_W-1:0]   span;
  logic [PROD_W-1:0]   prod;
  logic [AREA_W-1:0]   sat;

  assign empty_o        = !outv_q;
  assign largest_area_o = area_q;

  // rectangle width: closed at the popping column, or one past it on a row flush
  assign span = (state_q == B_FLUSH) ? SPAN_W'(col_q) + 1'b1 - SPAN_W'(top_start_q)
                                     : SPAN_W'(col_q) - SPAN_W'(top_start_q);
  assign prod = PROD_W'(top_h_q) * PROD_W'(span);
  assign sat  = (prod > PROD_W'(AREA_MAX)) ? AREA_MAX : prod[AREA_W-1:0];

  mora_ram #(.WIDTH(STK_W), .DEPTH(MAX_COLS)) u_sram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({start_q, h_q}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign waddr = depth_q[COL_W-1:0];
  assign raddr = COL_W'(depth_q - DEPTH_W'(2));

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    top_start_d = top_start_q;
    top_h_d     = top_h_q;
    start_d     = start_q;
    col_d       = col_q;
    h_d         = h_q;
    end_d       = end_q;
    last_d      = last_q;
    flush_d     = flush_q;
    best_d      = best_q;
    area_d      = area_q;
    outv_d      = outv_q;
    we          = 1'b0;
    re          = 1'b0;
    q_pop_o     = 1'b0;
    score_en    = 1'b0;

    if (pop_i && outv_q) outv_d = 1'b0;

    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          col_d   = q_data_i.col;
          h_d     = q_data_i.h;
          end_d   = q_data_i.end_row;
          last_d  = q_data_i.last;
          start_d = q_data_i.col;
          state_d = B_CMP;
        end
      end
      B_CMP: begin
        if (depth_q != '0 && top_h_q >= h_q) begin
          score_en = 1'b1;
          start_d  = top_start_q;
          depth_d  = depth_q - 1'b1;
          re       = 1'b1;
          flush_d  = 1'b0;
          state_d  = B_LOAD;
        end else begin
          if (depth_q < DEPTH_W'(MAX_COLS)) begin
            we          = 1'b1;
            top_start_d = start_q;
            top_h_d     = h_q;
            depth_d     = depth_q + 1'b1;
          end
          state_d = end_q ? B_FLUSH : B_IDLE;
        end
      end
      B_LOAD: begin
        // new top of stack comes from RAM; stale when the stack emptied
        top_start_d = rdata[STK_W-1:H_W];
        top_h_d     = rdata[H_W-1:0];
        state_d     = flush_q ? B_FLUSH : B_CMP;
      end
      B_FLUSH: begin
        if (depth_q != '0) begin
          score_en = 1'b1;
          depth_d  = depth_q - 1'b1;
          re       = 1'b1;
          flush_d  = 1'b1;
          state_d  = B_LOAD;
        end else if (!last_q) begin
          state_d = B_IDLE;
        end else if (!outv_q || pop_i) begin
          outv_d  = 1'b1;
          area_d  = best_q;
          best_d  = '0;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase

    if (score_en && sat > best_q) best_d = sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      depth_q     <= '0;
      best_q      <= '0;
      outv_q      <= 1'b0;
      flush_q     <= 1'b0;
      top_start_q <= '0;
      top_h_q     <= '0;
      start_q     <= '0;
      col_q       <= '0;
      h_q         <= '0;
      end_q       <= 1'b0;
      last_q      <= 1'b0;
      area_q      <= '0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      best_q      <= best_d;
      outv_q      <= outv_d;
      flush_q     <= flush_d;
      top_start_q <= top_start_d;
      top_h_q     <= top_h_d;
      start_q     <= start_d;
      col_q       <= col_d;
      h_q         <= h_d;
      end_q       <= end_d;
      last_q      <= last_d;
      area_q      <= area_d;
    end
  end

endmodule
`default_nettype wire

/* hdl/max_ones_rectangle_area_core.sv */
// Largest all-ones rectangle of a binary matrix streamed in row-major order.
// Input queue side: drive cell_req_i/last_cell_i with push; a word is taken
// at a clock edge with push high and full low. Each row holds row_width
// cells (0 acts as 1, above 1024 acts as 1024), written through
// row_width_we_i/row_width_i while the block is idle.
// Result queue side: after the word marked last_cell_i, largest_area_o is
// shown while empty is low and leaves on an edge with pop high.
// Flow: the front reads the column-height RAM for a word, then writes it,
// taking no new word in between. The back reads each word from the queue,
// then pushes it onto the stack, and for each stack pop scores, then reads
// the stack RAM; pops average at most one per word, so the back sets the
// sustained rate and the 4-entry queue between the two absorbs bursts.
// After the last word the back pops and scores each stack entry, then
// loads the best area into the result register. A stalled result register
// holds the back, which then fills the queue and raises full.
// Reset: empty stack, all heights zero, best area zero, row_width 1; no
// clearing pass is needed. All but row_width hold again after each matrix ends.
`default_nettype none
module max_ones_rectangle_area_core
  import mora_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              row_width_we_i,
  input  wire logic [WID_W-1:0]  row_width_i,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              cell_req_i,
  input  wire logic              last_cell_i,
  output logic                   empty,
  input  wire logic              pop,
  output logic [AREA_W-1:0]      largest_area_o
);

  logic [WID_W-1:0] row_width_q;
  logic             q_push, q_pop, q_full, q_empty;
  qent_t            q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= WID_W'(1);
    end else if (row_width_we_i) begin
      row_width_q <= row_width_i;
    end
  end

  mora_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_width_i (row_width_q),
    .push_i      (push),
    .cell_i      (cell_req_i),
    .last_i      (last_cell_i),
    .full_o      (full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .q_full_i    (q_full)
  );

  mora_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mora_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_data_i       (q_rdata),
    .q_pop_o        (q_pop),
    .pop_i          (pop),
    .empty_o        (empty),
    .largest_area_o (largest_area_o)
  );

endmodule
`default_nettype wire

/* hdl/mora_checker.sv */
`default_nettype none
module mora_checker
  import mora_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              push,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [AREA_W-1:0] largest_area_o
);

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(largest_area_o)))
    else $error("result changed while waiting");

  // no rectangle can exceed MAX_COLS * MAX_ROWS cells
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (largest_area_o <= AREA_W'(MAX_COLS * MAX_ROWS)))
    else $error("area out of range");

  // front is busy with the height update after taking a word
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front took a word while updating");

endmodule

bind max_ones_rectangle_area_core mora_checker u_mora_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .push           (push),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .largest_area_o (largest_area_o)
);
`default_nettype wire

/* tb/max_ones_rectangle_area_core_test.sv */
`default_nettype none
module max_ones_rectangle_area_core_test;
  import mora_pkg::*;

  typedef struct packed {
    logic filled;
    logic last;
  } cell_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              row_width_we_i = 1'b0;
  logic [WID_W-1:0]  row_width_i = '0;
  logic              push = 1'b0;
  logic              full;
  logic              cell_req_i = 1'b0;
  logic              last_cell_i = 1'b0;
  logic              empty;
  logic              pop = 1'b0;
  logic [AREA_W-1:0] largest_area_o;

  max_ones_rectangle_area_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .row_width_we_i(row_width_we_i),
    .row_width_i   (row_width_i),
    .push          (push),
    .full          (full),
    .cell_req_i    (cell_req_i),
    .last_cell_i   (last_cell_i),
    .empty         (empty),
    .pop           (pop),
    .largest_area_o(largest_area_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // predictor state
  int unsigned               cur_width;
  int unsigned               col_height [MAX_COLS];
  int unsigned               bar_start  [MAX_COLS];
  int unsigned               bar_height [MAX_COLS];
  int unsigned               bar_count;
  int unsigned               cur_col;
  int unsigned               best_so_far;
  logic [AREA_W-1:0]         area_queue [$];

  cell_word_t                cell_queue [$];
  int                        send_idle_pct;
  int                        recv_idle_pct;
  bit                        recv_hold;
  int                        hold_left;
  int                        errors;
  int                        results_seen;
  int                        words_sent;
  int                        quiet_cycles;

  localparam int QUIET_LIMIT = 20000;

  function automatic void clear_matrix();
    for (int i = 0; i < MAX_COLS; i++) col_height[i] = 0;
    bar_count = 0;
    cur_col = 0;
    best_so_far = 0;
  endfunction

  function automatic void score(int unsigned h, int unsigned w);
    longint unsigned a;
    a = longint'(h) * longint'(w);
    if (a > AREA_MAX) a = AREA_MAX;
    if (a > best_so_far) best_so_far = int'(a);
  endfunction

  function automatic void predict_area(cell_word_t wd);
    int unsigned width, c, h, start;
    width = (cur_width == 0) ? 1 : (cur_width > MAX_COLS ? MAX_COLS : cur_width);
    c = (cur_col >= MAX_COLS) ? MAX_COLS - 1 : cur_col;
    h = col_height[c];
    if (wd.filled) h = (h < MAX_ROWS) ? h + 1 : MAX_ROWS;
    else h = 0;
    col_height[c] = h;
    start = c;
    while (bar_count > 0 && bar_height[bar_count-1] >= h) begin
      bar_count--;
      score(bar_height[bar_count], c - bar_start[bar_count]);
      start = bar_start[bar_count];
    end
    if (bar_count < MAX_COLS) begin
      bar_start[bar_count] = start;
      bar_height[bar_count] = h;
      bar_count++;
    end
    if (wd.last || c + 1 >= width) begin
      while (bar_count > 0) begin
        bar_count--;
        score(bar_height[bar_count], c + 1 - bar_start[bar_count]);
      end
      cur_col = 0;
    end else begin
      cur_col = c + 1;
    end
    if (wd.last) begin
      area_queue.insert(area_queue.size(), best_so_far[AREA_W-1:0]);
      clear_matrix();
    end
  endfunction

  task automatic report(string what, logic [AREA_W-1:0] got, logic [AREA_W-1:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (push && !full) begin
      predict_area({cell_req_i, last_cell_i});
      words_sent++;
    end
    if ((!push || !full) && cell_queue.size() > 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      push <= 1'b1;
      cell_req_i <= cell_queue[0].filled;
      last_cell_i <= cell_queue[0].last;
      void'(cell_queue.pop_front());
    end else if (!push || !full) begin
      push <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      results_seen++;
      if (area_queue.size() == 0) begin
        report("unexpected word", largest_area_o, '0);
      end else begin
        if (largest_area_o !== area_queue[0])
          report("largest_area", largest_area_o, area_queue[0]);
        void'(area_queue.pop_front());
      end
    end
    if (hold_left > 0) hold_left <= hold_left - 1;
    pop <= !recv_hold && hold_left == 0 && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cell_queue.size() == 0 &&
        area_queue.size() == 0 && !push)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("max_ones_rectangle_area_core regression: fail");
      $finish;
    end
  end

  task automatic add_matrix(int unsigned width, int unsigned rows, int unsigned tail,
                            int pct_one);
    int unsigned n;
    n = width * rows + tail;
    if (n == 0) n = 1;
    for (int unsigned i = 0; i < n; i++) begin
      cell_word_t wd;
      wd.filled = ($urandom_range(99) < pct_one);
      wd.last = (i == n - 1);
      cell_queue.insert(cell_queue.size(), wd);
    end
  endtask

  // cells with no last mark, leaving the matrix open
  task automatic add_cells(int unsigned n, int pct_one);
    cell_word_t wd;
    for (int unsigned i = 0; i < n; i++) begin
      wd.filled = ($urandom_range(99) < pct_one);
      wd.last = 1'b0;
      cell_queue.insert(cell_queue.size(), wd);
    end
  endtask

  task automatic wait_drained();
    while (cell_queue.size() > 0 || push || area_queue.size() > 0) @(posedge clk_i);
    repeat (4 + 2 * MAX_COLS / 16) @(posedge clk_i);
  endtask

  task automatic set_width(int unsigned w);
    @(posedge clk_i);
    cur_width = w & 11'h7ff;
    row_width_we_i <= 1'b1;
    row_width_i <= w[WID_W-1:0];
    @(posedge clk_i);
    row_width_we_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned words);
    int unsigned target;
    target = words_sent + words;
    while (words_sent < target) begin
      int unsigned w, r;
      w = $urandom_range(1, 8);
      if ($urandom_range(9) == 0) w = $urandom_range(9, 40);
      set_width(w);
      repeat ($urandom_range(1, 4)) begin
        r = $urandom_range(1, 5);
        add_matrix(w, r, $urandom_range(0, w - 1),
                   $urandom_range(3) == 0 ? 50 : 85);
      end
      wait_drained();
    end
  endtask

  initial begin
    cur_width = 1;
    clear_matrix();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold = 1'b0;
    hold_left = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default width, all zeros, all ones
    add_matrix(1, 3, 0, 0);
    add_matrix(1, 3, 0, 100);
    wait_drained();
    set_width(0);
    add_matrix(1, 2, 0, 100);
    wait_drained();
    set_width(4);
    add_matrix(4, 3, 2, 100);        // partial last row
    add_matrix(4, 2, 0, 0);
    wait_drained();
    set_width(11'h7ff);              // wider than the block, acts as max
    add_matrix(0, 0, 3, 100);
    wait_drained();
    // width changed mid-row: col already past the new width
    set_width(6);
    add_cells(4, 100);
    while (cell_queue.size() > 0 || push) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    set_width(2);
    add_matrix(0, 0, 5, 100);
    wait_drained();

    // long receiver hold while the sender keeps pushing
    set_width(3);
    recv_hold = 1'b1;
    repeat (5) add_matrix(3, 2, 0, 80);
    @(posedge clk_i);
    hold_left <= 400;
    recv_hold = 1'b0;
    wait_drained();

    send_idle_pct = 16; recv_idle_pct = 53;
    random_phase(180);
    send_idle_pct = 53; recv_idle_pct = 16;
    random_phase(180);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_phase(180);

    $display("covered %0d cell words and %0d area results over widths 0..2047,",
             words_sent, results_seen);
    $display("with partial rows, mid-row width changes and long stalls");
    if (errors == 0 && area_queue.size() == 0) begin
      $display("max_ones_rectangle_area_core regression: pass");
    end else begin
      $display("max_ones_rectangle_area_core regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* max_ones_rectangle_area_core.f */
hdl/mora_pkg.sv
hdl/mora_ram.sv
hdl/mora_fifo.sv
hdl/mora_front.sv
hdl/mora_back.sv
hdl/max_ones_rectangle_area_core.sv
hdl/mora_checker.sv
tb/max_ones_rectangle_area_core_test.sv
